[sv/ppfr_pkg.sv]
// ----------------------------------------------------------------------------
// ppfr_pkg
// Shared types, byte codes and the CRC-16 byte step for the frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package ppfr_pkg;

  // Longest frame in raw bytes before the closing flag
  localparam int MAX_FRAME_BYTES = 2047;
  localparam int POS_W           = $clog2(MAX_FRAME_BYTES + 1);

  // Queue between front and back, depth is a power of two
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Payload length saturates at the output width
  localparam int LEN_W        = 11;
  localparam int IP_HDR_BYTES = 20;

  // Line byte codes
  localparam logic [7:0] ESC_BYTE   = 8'h7D;
  localparam logic [7:0] FLAG_BYTE  = 8'h7E;
  localparam logic [7:0] ESC_FLAG   = 8'h5E;
  localparam logic [7:0] ESC_ESC    = 8'h5D;
  localparam logic [7:0] CTRL_LIMIT = 8'h20;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] SUM_GOOD = 16'hFFFF;

  // Result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FCS  = 2'd1,
    ST_FLAG = 2'd2,
    ST_LEN  = 2'd3
  } status_t;

  // One queue entry: up to two payload bytes, then an optional status item
  typedef struct packed {
    logic [1:0]  n_bytes;
    logic [7:0]  byte0;
    logic [7:0]  byte1;
    logic        has_status;
    status_t     status;
    logic [31:0] header;
  } entry_t;

  // Reflected CRC-16, one byte
  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] d);
    logic [15:0] c;
    c = crc ^ {8'h00, d};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[sv/ppfr_front.sv]
// ----------------------------------------------------------------------------
// ppfr_front
// Takes raw line bytes, delays them by three so the FCS stays out of the CRC,
// captures the header, unescapes the payload and builds queue entries.
// ----------------------------------------------------------------------------
`default_nettype none

module ppfr_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            accept,
  input  wire logic [7:0]      frame_byte,
  input  wire logic            end_of_frame,
  output      logic            push,
  output      ppfr_pkg::entry_t entry
);
  import ppfr_pkg::*;

  logic [7:0]       tail [3];
  logic [7:0]       tail_next [3];
  logic [15:0]      crc, crc_next;
  logic [POS_W-1:0] pos, pos_next;
  logic             esc, esc_next;
  logic [7:0]       open_flag, open_flag_next;
  logic [31:0]      hdr, hdr_next;
  logic             ovl, ovl_next;

  logic             do_commit;
  logic [POS_W-1:0] q;
  logic [7:0]       cb;
  logic [1:0]       e_cnt;
  logic [7:0]       e_b [2];
  status_t          st;

  assign cb = tail[0];
  assign q  = pos - POS_W'(3);

  always_comb begin
    tail_next      = tail;
    crc_next       = crc;
    pos_next       = pos;
    esc_next       = esc;
    open_flag_next = open_flag;
    hdr_next       = hdr;
    ovl_next       = ovl;
    do_commit      = 1'b0;
    e_cnt          = 2'd0;
    e_b[0]         = 8'h00;
    e_b[1]         = 8'h00;
    st             = ST_OK;
    entry          = '0;

    // Advance the delay line or drop an overlong byte
    if (!end_of_frame) begin
      if (pos >= POS_W'(MAX_FRAME_BYTES)) begin
        ovl_next = 1'b1;
      end else begin
        do_commit    = (pos >= POS_W'(3));
        tail_next[0] = tail[1];
        tail_next[1] = tail[2];
        tail_next[2] = frame_byte;
        pos_next     = pos + POS_W'(1);
      end
    end else begin
      do_commit = !ovl && (pos >= POS_W'(7));
    end

    // Commit the oldest delayed byte
    if (do_commit) begin
      crc_next = crc16_step(crc, cb);
      if (q == POS_W'(0)) begin
        open_flag_next = cb;
      end else if (q == POS_W'(1)) begin
        hdr_next[31:24] = cb;
      end else if (q == POS_W'(2)) begin
        hdr_next[23:16] = cb;
      end else if (q == POS_W'(3)) begin
        hdr_next[15:8] = cb;
      end else if (q == POS_W'(4)) begin
        hdr_next[7:0] = cb;
      end else begin
        if (esc && (cb == ESC_FLAG)) begin
          esc_next = 1'b0;
          e_b[0]   = FLAG_BYTE;
          e_cnt    = 2'd1;
        end else if (esc && (cb == ESC_ESC)) begin
          esc_next = 1'b0;
          e_b[0]   = ESC_BYTE;
          e_cnt    = 2'd1;
        end else if (esc && (cb < CTRL_LIMIT)) begin
          esc_next = 1'b0;
          e_b[0]   = cb;
          e_cnt    = 2'd1;
        end else begin
          // A dangling escape passes through, then the byte is taken afresh
          if (esc) begin
            e_b[0] = ESC_BYTE;
            e_cnt  = 2'd1;
          end
          if (cb == ESC_BYTE) begin
            esc_next = 1'b1;
          end else begin
            esc_next     = 1'b0;
            e_b[e_cnt[0]] = cb;
            e_cnt        = e_cnt + 2'd1;
          end
        end
      end
    end

    // Close the frame: trailing escape, status, then clear all frame state
    if (end_of_frame) begin
      if (ovl || (pos < POS_W'(7))) begin
        st = ST_LEN;
      end else begin
        if (esc_next) begin
          e_b[e_cnt[0]] = ESC_BYTE;
          e_cnt        = e_cnt + 2'd1;
        end
        if ({tail[2], tail[1]} != crc_next) begin
          st = ST_FCS;
        end else if (frame_byte != open_flag_next) begin
          st = ST_FLAG;
        end else begin
          st = ST_OK;
        end
      end
      entry.has_status = 1'b1;
      entry.status     = st;
      entry.header     = hdr_next;
      crc_next         = CRC_INIT;
      pos_next         = '0;
      esc_next         = 1'b0;
      open_flag_next   = 8'h00;
      hdr_next         = 32'h0;
      ovl_next         = 1'b0;
    end

    entry.n_bytes = e_cnt;
    entry.byte0   = e_b[0];
    entry.byte1   = e_b[1];
  end

  assign push = accept && ((e_cnt != 2'd0) || end_of_frame);

  // Hold frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      crc       <= CRC_INIT;
      pos       <= '0;
      esc       <= 1'b0;
      open_flag <= 8'h00;
      hdr       <= 32'h0;
      ovl       <= 1'b0;
    end else if (accept) begin
      crc       <= crc_next;
      pos       <= pos_next;
      esc       <= esc_next;
      open_flag <= open_flag_next;
      hdr       <= hdr_next;
      ovl       <= ovl_next;
    end
  end

  // Shift the delay line
  always_ff @(posedge clk) begin
    if (accept) begin
      tail <= tail_next;
    end
  end

endmodule

`default_nettype wire

[sv/ppfr_queue.sv]
// ----------------------------------------------------------------------------
// ppfr_queue
// Short first-in first-out queue of entries between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module ppfr_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire ppfr_pkg::entry_t push_data,
  input  wire logic             pop,
  output      ppfr_pkg::entry_t head,
  output      logic             full,
  output      logic             empty
);
  import ppfr_pkg::*;

  entry_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;

  assign full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

[sv/ppfr_back.sv]
// ----------------------------------------------------------------------------
// ppfr_back
// Splits queue entries into result items, keeps the payload count and the
// ones'-complement header sum, and drives the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ppfr_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire ppfr_pkg::entry_t head,
  input  wire logic             empty,
  output      logic             pop,
  output      logic             result_valid,
  input  wire logic             result_stall,
  output      logic             kind,
  output      logic [7:0]       payload_byte,
  output      logic [7:0]       address_field,
  output      logic [7:0]       control_field,
  output      logic [15:0]      protocol_type,
  output      logic [1:0]       status,
  output      logic             ip_header_ok,
  output      logic [10:0]      payload_length,
  output      logic             last
);
  import ppfr_pkg::*;

  logic [1:0]       part;
  logic [1:0]       n_parts;
  logic             load;
  logic             last_part;
  logic             is_status;
  logic [7:0]       pb;
  logic [LEN_W-1:0] cnt;
  logic [16:0]      sum;
  logic [7:0]       high;
  logic [17:0]      raw_sum;
  logic [16:0]      folded;
  logic             ip_ok;

  assign load      = !empty && (!result_valid || !result_stall);
  assign n_parts   = head.n_bytes + {1'b0, head.has_status};
  assign last_part = (part == (n_parts - 2'd1));
  assign is_status = (part == head.n_bytes);
  assign pop       = load && last_part;
  assign pb        = part[0] ? head.byte1 : head.byte0;

  // Add one header word with end-around carry
  assign raw_sum = {1'b0, sum} + {2'b00, high, pb};
  assign folded  = {1'b0, raw_sum[15:0]} + {15'h0, raw_sum[17:16]};
  assign ip_ok   = (cnt >= LEN_W'(IP_HDR_BYTES)) && (sum == {1'b0, SUM_GOOD});

  // Hold control state and the running header check
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      part         <= 2'd0;
      cnt          <= '0;
      sum          <= '0;
      high         <= 8'h00;
    end else begin
      if (load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      if (load) begin
        part <= last_part ? 2'd0 : part + 2'd1;
        if (is_status) begin
          cnt  <= '0;
          sum  <= '0;
          high <= 8'h00;
        end else begin
          if (cnt < LEN_W'(IP_HDR_BYTES)) begin
            if (!cnt[0]) begin
              high <= pb;
            end else begin
              sum <= folded;
            end
          end
          if (cnt != {LEN_W{1'b1}}) begin
            cnt <= cnt + LEN_W'(1);
          end
        end
      end
    end
  end

  // Load the output register
  always_ff @(posedge clk) begin
    if (load) begin
      if (is_status) begin
        kind           <= KIND_STATUS;
        payload_byte   <= 8'h00;
        address_field  <= head.header[31:24];
        control_field  <= head.header[23:16];
        protocol_type  <= head.header[15:0];
        status         <= head.status;
        ip_header_ok   <= ip_ok;
        payload_length <= cnt;
        last           <= 1'b1;
      end else begin
        kind           <= KIND_PAYLOAD;
        payload_byte   <= pb;
        address_field  <= 8'h00;
        control_field  <= 8'h00;
        protocol_type  <= 16'h0000;
        status         <= ST_OK;
        ip_header_ok   <= 1'b0;
        payload_length <= '0;
        last           <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

[sv/ppp_style_frame_receiver.sv]
// ----------------------------------------------------------------------------
// ppp_style_frame_receiver
// Byte-wide frame receiver: unescapes payload, checks CRC-16 FCS and flags.
// ----------------------------------------------------------------------------
// Input channel: one raw line byte per item on frame_byte, with end_of_frame
// set on the closing flag. Output channel: one result item per unescaped
// payload byte (kind 0), then one status item (kind 1, last 1) per frame.
// Both channels use valid/stall; an item moves when valid is high and stall
// is low.
// A byte is committed three bytes after it arrives, so its payload result
// can only appear once three later bytes (or the closing flag) are taken;
// at the accepting edge it enters the queue, and then the output register.
// The front takes one byte per cycle and the back emits one result per
// cycle when not stalled, so a byte that yields two results, or a closing
// flag that yields up to three, holds the back longer. A four-entry queue
// between the two absorbs this; frame_stall rises only when it is full.
// While result_stall is high the output register holds its item and the
// queue fills. Reset clears all frame state, the queue and the output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module ppp_style_frame_receiver (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        frame_valid,
  output      logic        frame_stall,
  input  wire logic [7:0]  frame_byte,
  input  wire logic        end_of_frame,
  output      logic        result_valid,
  input  wire logic        result_stall,
  output      logic        kind,
  output      logic [7:0]  payload_byte,
  output      logic [7:0]  address_field,
  output      logic [7:0]  control_field,
  output      logic [15:0] protocol_type,
  output      logic [1:0]  status,
  output      logic        ip_header_ok,
  output      logic [10:0] payload_length,
  output      logic        last
);
  import ppfr_pkg::*;

  logic   accept;
  logic   push;
  logic   pop;
  logic   full;
  logic   empty;
  entry_t entry;
  entry_t head;

  assign frame_stall = full;
  assign accept      = frame_valid && !full;

  ppfr_front u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .frame_byte   (frame_byte),
    .end_of_frame (end_of_frame),
    .push         (push),
    .entry        (entry)
  );

  ppfr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (entry),
    .pop       (pop),
    .head      (head),
    .full      (full),
    .empty     (empty)
  );

  ppfr_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head           (head),
    .empty          (empty),
    .pop            (pop),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .kind           (kind),
    .payload_byte   (payload_byte),
    .address_field  (address_field),
    .control_field  (control_field),
    .protocol_type  (protocol_type),
    .status         (status),
    .ip_header_ok   (ip_header_ok),
    .payload_length (payload_length),
    .last           (last)
  );

endmodule

`default_nettype wire

[tb/sv/frame_result_checker.sv]
// ----------------------------------------------------------------------------
// frame_result_checker
// Watches both channels of the frame receiver, predicts its result items
// from the accepted line bytes and compares them field by field in order.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_result_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        frame_valid,
  input  wire logic        frame_stall,
  input  wire logic [7:0]  frame_byte,
  input  wire logic        end_of_frame,
  input  wire logic        result_valid,
  input  wire logic        result_stall,
  input  wire logic        kind,
  input  wire logic [7:0]  payload_byte,
  input  wire logic [7:0]  address_field,
  input  wire logic [7:0]  control_field,
  input  wire logic [15:0] protocol_type,
  input  wire logic [1:0]  status,
  input  wire logic        ip_header_ok,
  input  wire logic [10:0] payload_length,
  input  wire logic        last,
  output int               error_count,
  output int               expected_count
);
  timeunit 1ns;
  timeprecision 1ps;

  import ppfr_pkg::*;

  typedef struct {
    logic             kind;
    logic [7:0]       pbyte;
    logic [7:0]       addr;
    logic [7:0]       ctrl;
    logic [15:0]      ptype;
    status_t          st;
    logic             ipok;
    logic [LEN_W-1:0] plen;
    logic             lst;
  } rx_result_t;

  rx_result_t expected_results[$];
  rx_result_t want_item;

  // Receiver state as the line bytes leave it
  logic [7:0]       line_hist [3];
  logic [15:0]      crc_acc;
  int unsigned      frame_pos;
  logic             esc_seen;
  logic [7:0]       open_flag;
  logic [31:0]      hdr_bytes;
  logic [16:0]      hdr_sum;
  logic [7:0]       sum_hi;
  logic [LEN_W-1:0] pay_count;
  logic             too_long;

  task automatic report_mismatch(input string field, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("%0t ns: mismatch on %s: got %h, expected %h", $time, field, got, want);
    error_count++;
  endtask

  function automatic void clear_frame();
    line_hist = '{8'h00, 8'h00, 8'h00};
    crc_acc   = CRC_INIT;
    frame_pos = 0;
    esc_seen  = 1'b0;
    open_flag = 8'h00;
    hdr_bytes = 32'h0;
    hdr_sum   = 17'h0;
    sum_hi    = 8'h00;
    pay_count = '0;
    too_long  = 1'b0;
  endfunction

  function automatic void push_result(input logic k, input logic [7:0] pb, input status_t st,
                                      input logic ok, input logic [LEN_W-1:0] len,
                                      input logic lst);
    rx_result_t r;
    r.kind  = k;
    r.pbyte = pb;
    r.addr  = (k == KIND_STATUS) ? hdr_bytes[31:24] : 8'h00;
    r.ctrl  = (k == KIND_STATUS) ? hdr_bytes[23:16] : 8'h00;
    r.ptype = (k == KIND_STATUS) ? hdr_bytes[15:0] : 16'h0000;
    r.st    = st;
    r.ipok  = ok;
    r.plen  = len;
    r.lst   = lst;
    expected_results.push_back(r);
  endfunction

  // Emit one unescaped byte and fold it into the header sum
  function automatic void push_payload(input logic [7:0] b);
    logic [17:0] s;
    if (pay_count < IP_HDR_BYTES) begin
      if (!pay_count[0]) begin
        sum_hi = b;
      end else begin
        s = {1'b0, hdr_sum} + {2'b00, sum_hi, b};
        s = {2'b00, s[15:0]} + {16'h0000, s[17:16]};
        hdr_sum = s[16:0];
      end
    end
    if (pay_count != {LEN_W{1'b1}})
      pay_count++;
    push_result(KIND_PAYLOAD, b, ST_OK, 1'b0, '0, 1'b0);
  endfunction

  // Reflected CRC, one bit at a time, LSB first
  function automatic void crc_update(input logic [7:0] b);
    logic fb;
    for (int i = 0; i < 8; i++) begin
      fb = crc_acc[0] ^ b[i];
      crc_acc = crc_acc >> 1;
      if (fb)
        crc_acc ^= CRC_POLY;
    end
  endfunction

  function automatic void unescape_byte(input logic [7:0] b);
    if (esc_seen) begin
      esc_seen = 1'b0;
      if (b == ESC_FLAG) begin
        push_payload(FLAG_BYTE);
        return;
      end
      if (b == ESC_ESC) begin
        push_payload(ESC_BYTE);
        return;
      end
      if (b < CTRL_LIMIT) begin
        push_payload(b);
        return;
      end
      // Not a known escape: pass the escape byte, then take b afresh
      push_payload(ESC_BYTE);
    end
    if (b == ESC_BYTE)
      esc_seen = 1'b1;
    else
      push_payload(b);
  endfunction

  function automatic void commit_byte(input logic [7:0] b, input int unsigned q);
    crc_update(b);
    case (q)
      0: open_flag = b;
      1: hdr_bytes[31:24] = b;
      2: hdr_bytes[23:16] = b;
      3: hdr_bytes[15:8] = b;
      4: hdr_bytes[7:0] = b;
      default: unescape_byte(b);
    endcase
  endfunction

  function automatic void predict_line_byte(input logic [7:0] b, input logic eof);
    status_t     st;
    logic        ok;
    logic [15:0] rx_fcs;
    if (!eof) begin
      // Drop bytes past the longest frame
      if (frame_pos >= MAX_FRAME_BYTES) begin
        too_long = 1'b1;
        return;
      end
      if (frame_pos >= 3)
        commit_byte(line_hist[0], frame_pos - 3);
      line_hist[0] = line_hist[1];
      line_hist[1] = line_hist[2];
      line_hist[2] = b;
      frame_pos++;
      return;
    end
    if (too_long || frame_pos < 7) begin
      st = ST_LEN;
    end else begin
      commit_byte(line_hist[0], frame_pos - 3);
      // Escape left open at the end of the payload
      if (esc_seen) begin
        esc_seen = 1'b0;
        push_payload(ESC_BYTE);
      end
      rx_fcs = {line_hist[2], line_hist[1]};
      if (rx_fcs != crc_acc)
        st = ST_FCS;
      else if (b != open_flag)
        st = ST_FLAG;
      else
        st = ST_OK;
    end
    ok = (pay_count >= IP_HDR_BYTES) && (hdr_sum == {1'b0, SUM_GOOD});
    push_result(KIND_STATUS, 8'h00, st, ok, pay_count, 1'b1);
    clear_frame();
  endfunction

  // Compare the result first, then take the line byte of the same edge
  always @(posedge clk) begin
    if (rst) begin
      clear_frame();
      expected_results.delete();
    end else begin
      if ($isunknown({result_valid, frame_stall}))
        report_mismatch("handshake", {14'h0, result_valid, frame_stall}, 16'h0);
      if (result_valid && !result_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing expected", {7'h0, kind, payload_byte}, 16'h0);
        end else begin
          want_item = expected_results.pop_front();
          if (kind !== want_item.kind)
            report_mismatch("kind", 16'(kind), 16'(want_item.kind));
          if (payload_byte !== want_item.pbyte)
            report_mismatch("payload_byte", 16'(payload_byte), 16'(want_item.pbyte));
          if (address_field !== want_item.addr)
            report_mismatch("address_field", 16'(address_field), 16'(want_item.addr));
          if (control_field !== want_item.ctrl)
            report_mismatch("control_field", 16'(control_field), 16'(want_item.ctrl));
          if (protocol_type !== want_item.ptype)
            report_mismatch("protocol_type", protocol_type, want_item.ptype);
          if (status !== want_item.st)
            report_mismatch("status", 16'(status), 16'(want_item.st));
          if (ip_header_ok !== want_item.ipok)
            report_mismatch("ip_header_ok", 16'(ip_header_ok), 16'(want_item.ipok));
          if (payload_length !== want_item.plen)
            report_mismatch("payload_length", 16'(payload_length), 16'(want_item.plen));
          if (last !== want_item.lst)
            report_mismatch("last", 16'(last), 16'(want_item.lst));
        end
      end
      if (frame_valid && !frame_stall)
        predict_line_byte(frame_byte, end_of_frame);
    end
    expected_count = expected_results.size();
  end

endmodule

`default_nettype wire

[tb/sv/ppp_style_frame_receiver_tb.sv]
// ----------------------------------------------------------------------------
// ppp_style_frame_receiver_tb
// Drives escaped frames with valid CRC, broken FCS, wrong flags, short and
// noise frames into the receiver under random gaps and stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module ppp_style_frame_receiver_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ppfr_pkg::*;

  localparam int          RANDOM_ITEMS = 320;
  localparam int          CYCLE_LIMIT  = 600000;
  localparam logic [7:0]  ESC_XOR      = 8'h20;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        frame_valid = 1'b0;
  logic        frame_stall;
  logic [7:0]  frame_byte = 8'h00;
  logic        end_of_frame = 1'b0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic        kind;
  logic [7:0]  payload_byte;
  logic [7:0]  address_field;
  logic [7:0]  control_field;
  logic [15:0] protocol_type;
  logic [1:0]  status;
  logic        ip_header_ok;
  logic [10:0] payload_length;
  logic        last;

  int error_count;
  int expected_count;

  ppp_style_frame_receiver u_top (
    .clk            (clk),
    .rst            (rst),
    .frame_valid    (frame_valid),
    .frame_stall    (frame_stall),
    .frame_byte     (frame_byte),
    .end_of_frame   (end_of_frame),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .kind           (kind),
    .payload_byte   (payload_byte),
    .address_field  (address_field),
    .control_field  (control_field),
    .protocol_type  (protocol_type),
    .status         (status),
    .ip_header_ok   (ip_header_ok),
    .payload_length (payload_length),
    .last           (last)
  );

  frame_result_checker u_check (
    .clk            (clk),
    .rst            (rst),
    .frame_valid    (frame_valid),
    .frame_stall    (frame_stall),
    .frame_byte     (frame_byte),
    .end_of_frame   (end_of_frame),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .kind           (kind),
    .payload_byte   (payload_byte),
    .address_field  (address_field),
    .control_field  (control_field),
    .protocol_type  (protocol_type),
    .status         (status),
    .ip_header_ok   (ip_header_ok),
    .payload_length (payload_length),
    .last           (last),
    .error_count    (error_count),
    .expected_count (expected_count)
  );

  always #6 clk = ~clk;

  // Give up on a hung run
  int cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver: after each taken result, stall for a random count of cycles
  int stall_left = 0;
  bit rx_burst = 1'b0;
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if ($urandom_range(0, 39) == 0)
        rx_burst = ~rx_burst;
      stall_left = rx_burst ? 0 : $urandom_range(0, 6);
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      result_stall <= 1'b1;
      stall_left--;
    end else begin
      result_stall <= 1'b0;
    end
  end

  // Sender
  bit         tx_burst = 1'b0;
  logic [7:0] raw_frame[$];
  logic [7:0] body[$];
  int         line_items = 0;

  // Present one line byte; called and returns at a falling edge
  task automatic send_item(input logic [7:0] b, input logic eof);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      frame_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    frame_valid  <= 1'b1;
    frame_byte   <= b;
    end_of_frame <= eof;
    do @(posedge clk); while (frame_stall);
    @(negedge clk);
  endtask

  task automatic send_frame(input logic [7:0] close_flag);
    foreach (raw_frame[i])
      send_item(raw_frame[i], 1'b0);
    send_item(close_flag, 1'b1);
    line_items += raw_frame.size() + 1;
  endtask

  // Hold the sender until every expected result is out
  task automatic wait_results_drained();
    frame_valid <= 1'b0;
    do @(negedge clk); while (expected_count != 0);
  endtask

  // Append the FCS over all raw bytes so far, low byte first
  task automatic append_fcs();
    logic [15:0] c;
    c = CRC_INIT;
    foreach (raw_frame[i]) begin
      c ^= {8'h00, raw_frame[i]};
      repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    raw_frame.push_back(c[7:0]);
    raw_frame.push_back(c[15:8]);
  endtask

  task automatic build_frame(input logic [7:0] flag, input logic [7:0] addr,
                             input logic [7:0] ctrl, input logic [15:0] ptype,
                             input int n, input bit ip_style, input bit odd_escapes);
    int unsigned acc;
    raw_frame.delete();
    body.delete();
    raw_frame.push_back(flag);
    raw_frame.push_back(addr);
    raw_frame.push_back(ctrl);
    raw_frame.push_back(ptype[15:8]);
    raw_frame.push_back(ptype[7:0]);
    repeat (n) body.push_back(8'($urandom));
    // Fill in a header checksum so the ones' complement sum comes out all ones
    if (ip_style) begin
      acc = 0;
      for (int i = 0; i < IP_HDR_BYTES; i += 2) begin
        if (i != 10) begin
          acc += {body[i], body[i+1]};
          acc = (acc & 32'hFFFF) + (acc >> 16);
        end
      end
      acc = (acc & 32'hFFFF) + (acc >> 16);
      body[10] = ~acc[15:8];
      body[11] = ~acc[7:0];
    end
    // Escape the payload onto the line, with stray escapes when asked
    foreach (body[i]) begin
      if (odd_escapes && $urandom_range(0, 7) == 0)
        raw_frame.push_back(ESC_BYTE);
      if (body[i] == FLAG_BYTE || body[i] == ESC_BYTE) begin
        raw_frame.push_back(ESC_BYTE);
        raw_frame.push_back(body[i] ^ ESC_XOR);
      end else if (body[i] < CTRL_LIMIT && $urandom_range(0, 1) == 1) begin
        raw_frame.push_back(ESC_BYTE);
        raw_frame.push_back(body[i]);
      end else begin
        raw_frame.push_back(body[i]);
      end
    end
    if (odd_escapes && $urandom_range(0, 1) == 1)
      raw_frame.push_back(ESC_BYTE);
    append_fcs();
  endtask

  initial begin
    int         frame_no;
    int         sel;
    int         n;
    int         idx;
    logic [7:0] flag;
    logic [7:0] close_flag;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: closing flag alone, a minimal frame, every escape form
    raw_frame.delete();
    send_frame(FLAG_BYTE);
    build_frame(FLAG_BYTE, 8'hFF, 8'h00, 16'hFFFF, 0, 1'b0, 1'b0);
    send_frame(FLAG_BYTE);
    raw_frame = '{FLAG_BYTE, 8'h00, 8'hFF, 8'h00, 8'h00,
                  ESC_BYTE, ESC_FLAG, ESC_BYTE, ESC_ESC, ESC_BYTE, 8'h01,
                  ESC_BYTE, ESC_BYTE, 8'h41, ESC_BYTE};
    append_fcs();
    send_frame(FLAG_BYTE);

    // Random frames, mostly well formed
    frame_no = 0;
    while (line_items < RANDOM_ITEMS) begin
      frame_no++;
      tx_burst = ($urandom_range(0, 3) == 0);
      if (frame_no == 8)
        wait_results_drained();
      sel  = $urandom_range(0, 99);
      flag = ($urandom_range(0, 3) == 0) ? 8'($urandom) : FLAG_BYTE;
      close_flag = flag;
      n = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 12);
      build_frame(flag, 8'($urandom), 8'($urandom), 16'($urandom), n,
                  n >= IP_HDR_BYTES && $urandom_range(0, 2) != 0, sel >= 55 && sel < 70);
      if (sel >= 70 && sel < 78) begin
        // Corrupt one FCS bit
        idx = raw_frame.size() - 1 - $urandom_range(0, 1);
        raw_frame[idx] ^= 8'(1 << $urandom_range(0, 7));
      end else if (sel >= 78 && sel < 86) begin
        close_flag = flag ^ 8'(1 << $urandom_range(0, 7));
      end else if (sel >= 86 && sel < 92) begin
        // Short frame
        raw_frame.delete();
        repeat ($urandom_range(0, 6)) raw_frame.push_back(8'($urandom));
      end else if (sel >= 92) begin
        // Line noise
        raw_frame.delete();
        repeat ($urandom_range(7, 24)) raw_frame.push_back(8'($urandom));
        close_flag = 8'($urandom);
      end
      send_frame(close_flag);
    end

    wait_results_drained();
    repeat (16) @(negedge clk);
    if (error_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

`default_nettype wire
